// File: hw/rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS decompressor.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // Default code layout: 12-bit backward distance, 4-bit length field.
  localparam int unsigned DISTANCE_BITS_DEF     = 12;
  localparam int unsigned LENGTH_FIELD_BITS_DEF = 4;

  // Shortest match; the length field holds length minus this.
  localparam int unsigned MIN_MATCH       = 2;
  // Tokens governed by one flag byte.
  localparam int unsigned TOKENS_PER_FLAG = 8;

  // Queue depths (powers of two).
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Input beat: one compressed byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_t;

  // Output beat: one decompressed byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  // Command from front to back: a literal (lo) or a raw 16-bit match code.
  typedef struct packed {
    logic       is_match;
    logic [7:0] hi;
    logic [7:0] lo;
  } cmd_t;

endpackage

// File: hw/rtl/lzsd_fifo.sv
// ----------------------------------------------------------------------------
// lzsd_fifo
// Small register FIFO with occupancy count; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module lzsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + CW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/lzsd_front.sv
// ----------------------------------------------------------------------------
// lzsd_front
// Token parser: tracks flag bits and turns literals and match codes
// into commands for the copy engine.
// ----------------------------------------------------------------------------
module lzsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzsd_pkg::in_t  in_data_i,
  output logic           full_o,
  output logic           cmd_push_o,
  output lzsd_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i
);
  import lzsd_pkg::*;

  localparam logic [1:0] PhFlag   = 2'd0;
  localparam logic [1:0] PhToken  = 2'd1;
  localparam logic [1:0] PhMatch2 = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] flag_q, flag_d;
  logic [3:0] tok_q, tok_d;
  logic [7:0] hi_q, hi_d;
  logic [3:0] tok_inc;
  logic       accept;

  assign full_o  = cmd_full_i;
  assign accept  = push_i && !cmd_full_i;
  assign tok_inc = tok_q + 4'd1;

  always_comb begin
    phase_d      = phase_q;
    flag_d       = flag_q;
    tok_d        = tok_q;
    hi_d         = hi_q;
    cmd_push_o   = 1'b0;
    cmd_o.is_match = (phase_q == PhMatch2);
    cmd_o.hi     = hi_q;
    cmd_o.lo     = in_data_i.in_byte;
    if (accept) begin
      if (in_data_i.stream_start) begin
        flag_d  = in_data_i.in_byte;
        tok_d   = '0;
        phase_d = PhToken;
      end else begin
        unique case (phase_q)
          PhToken: begin
            flag_d = {flag_q[6:0], 1'b0};
            tok_d  = tok_inc;
            if (flag_q[7]) begin
              hi_d    = in_data_i.in_byte;
              phase_d = PhMatch2;
            end else begin
              cmd_push_o     = 1'b1;
              cmd_o.is_match = 1'b0;
              phase_d = (tok_inc >= 4'(TOKENS_PER_FLAG)) ? PhFlag : PhToken;
            end
          end
          PhMatch2: begin
            cmd_push_o     = 1'b1;
            cmd_o.is_match = 1'b1;
            phase_d = (tok_q >= 4'(TOKENS_PER_FLAG)) ? PhFlag : PhToken;
          end
          default: begin
            // flag byte expected (unused code too)
            flag_d  = in_data_i.in_byte;
            tok_d   = '0;
            phase_d = PhToken;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFlag;
      flag_q  <= '0;
      tok_q   <= '0;
      hi_q    <= '0;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      tok_q   <= tok_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// File: hw/rtl/lzsd_back.sv
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: runs literals and matches against the history ring,
// one output byte per cycle while output credit allows, with read-after-write forwarding.
// ----------------------------------------------------------------------------
module lzsd_back #(
  parameter int unsigned DISTANCE_BITS     = lzsd_pkg::DISTANCE_BITS_DEF,
  parameter int unsigned LENGTH_FIELD_BITS = lzsd_pkg::LENGTH_FIELD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_empty_i,
  input  lzsd_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  output logic                           out_push_o,
  output lzsd_pkg::out_t                 out_o,
  input  logic [lzsd_pkg::OUT_CNT_W-1:0] out_count_i
);
  import lzsd_pkg::*;

  localparam int unsigned WinSize = 1 << DISTANCE_BITS;
  localparam int unsigned LenW    = LENGTH_FIELD_BITS + 1;
  localparam int unsigned CrW     = OUT_CNT_W + 1;

  // history ring
  logic [7:0] hist_mem [WinSize];
  logic [7:0] rdata_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;

  // current command
  logic                     cur_valid_q, cur_valid_d;
  logic                     cur_match_q, cur_match_d;
  logic [7:0]               cur_lit_q, cur_lit_d;
  logic [DISTANCE_BITS-1:0] cur_dist_q, cur_dist_d;
  logic [LenW-1:0]          cur_left_q, cur_left_d;

  // write position of the next issued byte
  logic [DISTANCE_BITS-1:0] wp_q, wp_d;

  // data stage
  logic                     dp_valid_q;
  logic                     dp_match_q;
  logic [7:0]               dp_lit_q;
  logic                     dp_last_q;
  logic [DISTANCE_BITS-1:0] dp_waddr_q;

  logic [15:0]              code;
  logic [15:0]              code_shr;
  logic [DISTANCE_BITS-1:0] new_dist;
  logic [LenW-1:0]          new_len;
  logic                     credit;
  logic                     issue;
  logic                     issue_last;
  logic                     rd_en;
  logic [DISTANCE_BITS-1:0] raddr;
  logic [7:0]               wdata;

  assign code     = {cmd_i.hi, cmd_i.lo};
  assign code_shr = code >> LENGTH_FIELD_BITS;
  assign new_dist = code_shr[DISTANCE_BITS-1:0];
  assign new_len  = LenW'(code[LENGTH_FIELD_BITS-1:0]) + LenW'(MIN_MATCH);

  // out FIFO slots already claimed plus the byte in flight
  assign credit = (CrW'(out_count_i) + CrW'(dp_valid_q)) < CrW'(OUT_DEPTH);

  assign issue      = cur_valid_q && credit;
  assign issue_last = !cur_match_q || (cur_left_q == LenW'(1));
  assign rd_en      = issue && cur_match_q;
  // distance zero wraps to the full window
  assign raddr      = wp_q - cur_dist_q;

  assign cmd_pop_o = !cmd_empty_i && (!cur_valid_q || (issue && issue_last));

  assign wdata        = !dp_match_q ? dp_lit_q : (fwd_q ? fwd_data_q : rdata_q);
  assign out_push_o   = dp_valid_q;
  assign out_o.out_byte = wdata;
  assign out_o.run_last = dp_last_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_match_d = cur_match_q;
    cur_lit_d   = cur_lit_q;
    cur_dist_d  = cur_dist_q;
    cur_left_d  = cur_left_q;
    wp_d        = wp_q;
    if (issue) begin
      wp_d       = wp_q + DISTANCE_BITS'(1);
      cur_left_d = cur_left_q - LenW'(1);
      if (issue_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (cmd_pop_o) begin
      cur_valid_d = 1'b1;
      cur_match_d = cmd_i.is_match;
      cur_lit_d   = cmd_i.lo;
      cur_dist_d  = new_dist;
      cur_left_d  = new_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      wp_q        <= '0;
      dp_valid_q  <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      wp_q        <= wp_d;
      dp_valid_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_match_q <= cur_match_d;
    cur_lit_q   <= cur_lit_d;
    cur_dist_q  <= cur_dist_d;
    cur_left_q  <= cur_left_d;
    if (issue) begin
      dp_match_q <= cur_match_q;
      dp_lit_q   <= cur_lit_q;
      dp_last_q  <= issue_last;
      dp_waddr_q <= wp_q;
    end
  end

  // ring: one write and one registered read per cycle; a read of the slot
  // written in the same cycle takes the written byte instead
  always_ff @(posedge clk_i) begin
    if (dp_valid_q) begin
      hist_mem[dp_waddr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q    <= hist_mem[raddr];
      fwd_q      <= dp_valid_q && (raddr == dp_waddr_q);
      fwd_data_q <= wdata;
    end
  end

endmodule

// File: hw/rtl/lzss_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_decompressor
// LZSS stream decompressor, one compressed byte per input beat.
// ----------------------------------------------------------------------------
// The host strips the 4-byte size header and pushes the compressed bytes one
// per beat, with stream_start set on the first flag byte of each stream. A
// flag byte and the first byte of a match give no output; a literal gives one
// output beat; the second byte of a match gives 2 to 17 beats (default code
// layout), run_last marking the final beat of each input byte. The parser
// takes one byte per cycle into a 2-entry command queue while it is not full;
// the copy engine behind it makes one output byte per cycle while the output
// queue has a free slot, reading the 4096-byte history ring through one
// registered read port. Bytes pass through the engine's data stage register
// before they reach the output queue. Match distance zero means the full
// window. The history ring is not cleared at reset: a match must only reach
// bytes already written since reset. No setup is needed.
// ----------------------------------------------------------------------------
module lzss_decompressor #(
  parameter int unsigned DISTANCE_BITS     = lzsd_pkg::DISTANCE_BITS_DEF,
  parameter int unsigned LENGTH_FIELD_BITS = lzsd_pkg::LENGTH_FIELD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // compressed side
  input  logic           push,
  output logic           full,
  input  lzsd_pkg::in_t  in_data_i,
  // decompressed side
  output logic           empty,
  input  logic           pop,
  output lzsd_pkg::out_t out_data_o
);
  import lzsd_pkg::*;

  cmd_t                 cmd_in, cmd_out;
  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_raw;
  out_t                 out_in;
  logic                 out_push;
  logic [$bits(out_t)-1:0] out_raw;
  logic [OUT_CNT_W-1:0] out_count;

  // parser: flag bits, token phase, match high byte
  lzsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // command queue decouples parsing from copying
  lzsd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty),
    .count_o ()
  );

  assign cmd_out = cmd_t'(cmd_raw);

  // copy engine and history ring
  lzsd_back #(
    .DISTANCE_BITS     (DISTANCE_BITS),
    .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_push_o  (out_push),
    .out_o       (out_in),
    .out_count_i (out_count)
  );

  // output queue; the engine only issues a byte when a slot is reserved,
  // so pushes here never see it full
  lzsd_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_data_o = out_t'(out_raw);

endmodule

// File: hw/rtl/lzsd_checker.sv
// ----------------------------------------------------------------------------
// lzsd_checker
// Port-level checks on the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzsd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           push,
  input logic           full,
  input lzsd_pkg::in_t  in_data_i,
  input logic           empty,
  input logic           pop,
  input lzsd_pkg::out_t out_data_o
);

  // both queues come out of reset empty
  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("queues not empty after reset");

  // a waiting beat stays offered until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("output beat withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  // a stream start is a flag byte and queues no command
  a_start_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && in_data_i.stream_start |=> !full)
    else $error("stream start filled the command queue");

endmodule

bind lzss_decompressor lzsd_checker u_chk (.*);

// File: tb/lzss_decompressor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzss_decompressor_tb
// Self-checking bench for the LZSS decompressor, one compressed byte per beat.
// ----------------------------------------------------------------------------
// An initial block builds the compressed stream: a short hand-made stream
// (literal extremes, short, long and overlapping matches, the farthest legal
// distance, a flag byte after eight tokens, restarts in the middle of a match
// and of a token run), then random streams with random restarts, one run per
// idling phase. The generator tracks how much history exists so that no match
// reaches bytes never written; the run is too short to fill the window, so
// full-window (zero) distances do not occur. The driver takes bytes off that
// queue, and on each accepted beat a behavioral decoder appends the expected
// output bytes. The monitor pops output beats and checks them in order.
// ----------------------------------------------------------------------------
module lzss_decompressor_tb;
  import lzsd_pkg::*;

  localparam int unsigned DB = DISTANCE_BITS_DEF;
  localparam int unsigned LB = LENGTH_FIELD_BITS_DEF;
  localparam int unsigned WIN = 1 << DB;
  localparam int unsigned MAX_LEN = (1 << LB) - 1 + MIN_MATCH;
  localparam int unsigned RAND_ITEMS = 65;  // per idling phase
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Parse position within the compressed stream.
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH2} parse_ph_e;

  // Pending compressed byte, tagged with the idling phase it belongs to.
  typedef struct packed {
    logic [1:0] seg;
    in_t        beat;
  } comp_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  out_t out_data;

  lzss_decompressor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Stream generator state: parse position and amount of history written.
  // --------------------------------------------------------------------------
  comp_byte_t comp_q[$];
  logic [1:0] gen_seg = 2'd0;
  parse_ph_e  gen_phase = PH_FLAG;
  logic [7:0] gen_flags = '0;
  int unsigned gen_tok = 0;
  int unsigned gen_written = 0;
  logic [15:0] gen_code = '0;

  // Queue one compressed byte and advance the parse tracker.
  function automatic void put(input logic [7:0] b, input logic s);
    comp_byte_t cb;
    cb.seg = gen_seg;
    cb.beat.in_byte = b;
    cb.beat.stream_start = s;
    comp_q.push_back(cb);
    if (s || gen_phase == PH_FLAG) begin
      gen_flags = b;
      gen_tok = 0;
      gen_phase = PH_TOKEN;
    end else if (gen_phase == PH_TOKEN) begin
      gen_tok++;
      if (gen_flags[7]) begin
        gen_phase = PH_MATCH2;
      end else begin
        gen_written++;
        gen_phase = (gen_tok >= TOKENS_PER_FLAG) ? PH_FLAG : PH_TOKEN;
      end
      gen_flags = gen_flags << 1;
    end else begin
      gen_written += (b & ((1 << LB) - 1)) + MIN_MATCH;
      gen_phase = (gen_tok >= TOKENS_PER_FLAG) ? PH_FLAG : PH_TOKEN;
    end
  endfunction

  // Distance WIN wraps to a zero field, which the block reads as WIN.
  function automatic logic [15:0] match_code(input int unsigned d, input int unsigned len);
    return (16'(d) << LB) | 16'(len - MIN_MATCH);
  endfunction

  function automatic void put_match(input int unsigned d, input int unsigned len);
    logic [15:0] code;
    code = match_code(d, len);
    put(code[15:8], 1'b0);
    put(code[7:0], 1'b0);
  endfunction

  // One byte of a random well-formed stream, with occasional restarts.
  // With fill set, every token is a longest match once history exists.
  function automatic void rand_item(input logic fill);
    logic [7:0] b;
    logic s;
    int unsigned maxd;
    int unsigned d;
    int unsigned len;
    s = 1'b0;
    if (gen_phase == PH_FLAG) begin
      b = fill ? 8'hff : 8'($urandom);
      s = !fill && ($urandom_range(9) == 0);
    end else if (!fill && $urandom_range(39) == 0) begin
      // broken sequence: new stream in the middle of a token run or match
      b = 8'($urandom);
      s = 1'b1;
    end else if (gen_phase == PH_MATCH2) begin
      b = gen_code[7:0];
    end else if (gen_flags[7]) begin
      maxd = (gen_written < WIN) ? gen_written : WIN;
      case ($urandom_range(3))
        0: d = 1;
        1: d = $urandom_range(1, (maxd < 32) ? maxd : 32);
        2: d = $urandom_range(1, maxd);
        default: d = maxd;
      endcase
      len = (fill || $urandom_range(3) == 0) ? MAX_LEN : $urandom_range(MIN_MATCH, MAX_LEN);
      gen_code = match_code(d, len);
      b = gen_code[15:8];
    end else begin
      b = 8'($urandom);
    end
    // with no history yet, the first token of a fresh flag byte is a literal
    if ((s || gen_phase == PH_FLAG) && gen_written == 0) b[7] = 1'b0;
    put(b, s);
  endfunction

  // --------------------------------------------------------------------------
  // Behavioral decoder: history window and parse state, fed per accepted beat.
  // --------------------------------------------------------------------------
  out_t        exp_q[$];
  logic [7:0]  dec_hist [WIN];
  logic [DB-1:0] dec_wpos = '0;
  logic [7:0]  dec_flags = '0;
  logic [3:0]  dec_tok = '0;
  parse_ph_e   dec_phase = PH_FLAG;
  logic [7:0]  dec_hi = '0;

  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_matches = 0;
  int unsigned n_restarts = 0;
  int unsigned n_err = 0;

  function automatic void emit_byte(input logic [7:0] v, input logic last);
    out_t r;
    dec_hist[dec_wpos] = v;
    dec_wpos = dec_wpos + 1'b1;
    r.out_byte = v;
    r.run_last = last;
    exp_q.push_back(r);
  endfunction

  task automatic decode_byte(input in_t beat);
    logic [15:0] code;
    logic [DB-1:0] src;
    int unsigned back_dist;
    int unsigned len;
    if (beat.stream_start || (dec_phase != PH_TOKEN && dec_phase != PH_MATCH2)) begin
      if (beat.stream_start && dec_phase != PH_FLAG) n_restarts++;
      dec_flags = beat.in_byte;
      dec_tok = '0;
      dec_phase = PH_TOKEN;
    end else if (dec_phase == PH_TOKEN) begin
      dec_tok = dec_tok + 1'b1;
      if (dec_flags[7]) begin
        dec_hi = beat.in_byte;
        dec_phase = PH_MATCH2;
      end else begin
        emit_byte(beat.in_byte, 1'b1);
        dec_phase = (dec_tok >= TOKENS_PER_FLAG) ? PH_FLAG : PH_TOKEN;
      end
      dec_flags = dec_flags << 1;
    end else begin
      code = {dec_hi, beat.in_byte};
      back_dist = (code >> LB) & (WIN - 1);
      if (back_dist == 0) begin
        back_dist = WIN;  // zero distance means the whole window
      end
      len = (code & ((1 << LB) - 1)) + MIN_MATCH;
      n_matches++;
      // byte by byte, so a copy may read what it has just written
      for (int unsigned i = 0; i < len; i++) begin
        src = dec_wpos - back_dist[DB-1:0];
        emit_byte(dec_hist[src], i == len - 1);
      end
      dec_phase = (dec_tok >= TOKENS_PER_FLAG) ? PH_FLAG : PH_TOKEN;
    end
  endtask

  // Idle percentage per phase: sender/receiver 27/53, then 53/27, then none.
  function automatic int unsigned idle_pct(input logic [1:0] seg, input logic rx);
    case (seg)
      2'd0: return rx ? 53 : 27;
      2'd1: return rx ? 27 : 53;
      default: return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: a beat moves at an edge with push high and full low.
  // --------------------------------------------------------------------------
  comp_byte_t drv_item;
  logic [1:0] rx_seg = 2'd0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(in_data);
        n_accepted++;
      end
      if (!push || !full) begin
        if (comp_q.size() != 0 && $urandom_range(99) >= idle_pct(comp_q[0].seg, 1'b0)) begin
          drv_item = comp_q.pop_front();
          in_data <= drv_item.beat;
          push <= 1'b1;
          rx_seg <= drv_item.seg;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops at random, checks each output beat against the oldest
  // expected byte.
  // --------------------------------------------------------------------------
  out_t exp_beat;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected output beat: byte %02h last %0b",
                   $time, out_data.out_byte, out_data.run_last);
          n_err++;
        end else begin
          exp_beat = exp_q.pop_front();
          n_checked++;
          if (out_data.out_byte !== exp_beat.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, exp_beat.out_byte, out_data.out_byte);
            n_err++;
          end
          if (out_data.run_last !== exp_beat.run_last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, exp_beat.run_last, out_data.run_last);
            n_err++;
          end
        end
      end
      pop <= ($urandom_range(99) >= idle_pct(rx_seg, 1'b1));
    end
  end

  // Watchdog: too long with no beat on either side ends the run.
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d bytes still expected",
               $time, WATCHDOG_LIMIT, exp_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  int unsigned n_total;

  initial begin
    // Hand-made stream. Flag 0x26: lit, lit, match, lit, lit, match, match, lit.
    put(8'h26, 1'b1);
    put(8'h00, 1'b0);
    put(8'hff, 1'b0);
    put_match(1, MIN_MATCH);          // shortest, overlapping copy
    put(8'h55, 1'b0);
    put(8'haa, 1'b0);
    put_match(3, MAX_LEN);            // longest, overlapping copy
    put_match(gen_written, 5);        // back to the very first byte
    put(8'h80, 1'b0);
    // eight tokens done: next byte is a flag without stream_start
    put(8'hff, 1'b0);
    put_match(1, MIN_MATCH);
    put(8'h01, 1'b0);                 // first match byte, then dropped
    put(8'hff, 1'b1);                 // restart in the middle of a match
    put_match(gen_written, MAX_LEN);
    put(8'h00, 1'b1);                 // restart in the middle of a token run
    put(8'h01, 1'b0);
    put(8'h80, 1'b0);
    put(8'h7f, 1'b0);
    put(8'hfe, 1'b0);

    // Random streams, one run per idling phase.
    repeat (RAND_ITEMS) rand_item(1'b0);
    gen_seg = 2'd1;
    repeat (RAND_ITEMS) rand_item(1'b0);
    gen_seg = 2'd2;
    repeat (RAND_ITEMS) rand_item(1'b0);
    n_total = comp_q.size();

    while (n_accepted < n_total || exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (exp_q.size() != 0) begin
      $display("%0t: %0d expected output bytes never arrived", $time, exp_q.size());
      n_err++;
    end
    $display("Run covered %0d compressed bytes and %0d checked output bytes,",
             n_accepted, n_checked);
    $display("with %0d matches and %0d mid-stream restarts.",
             n_matches, n_restarts);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
